>>> hdl/i2cms_pkg.sv
package i2cms_pkg;

  localparam int TX_MAX   = 16;
  localparam int RX_MAX   = 16;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = 4;
  localparam int STORE_N  = TX_MAX + 1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_EVENT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_REP_START   = 4'd1,
    ST_MT_SLA_ACK  = 4'd2,
    ST_MT_SLA_NACK = 4'd3,
    ST_MT_DATA_ACK = 4'd4,
    ST_MT_DATA_NACK = 4'd5,
    ST_ARB_LOST    = 4'd6,
    ST_MR_SLA_ACK  = 4'd7,
    ST_MR_SLA_NACK = 4'd8,
    ST_MR_DATA_ACK = 4'd9,
    ST_MR_DATA_NACK = 4'd10,
    ST_NO_INFO     = 4'd11,
    ST_BUS_ERROR   = 4'd12
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_XFER  = 3'd3,
    ACT_ACK   = 3'd4,
    ACT_NAK   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ERR_SUCCESS   = 3'd0,
    ERR_BUSY      = 3'd1,
    ERR_WADDR_NAK = 3'd2,
    ERR_DATA_NAK  = 3'd3,
    ERR_ARB_LOST  = 3'd4,
    ERR_RADDR_NAK = 3'd5,
    ERR_BUS       = 3'd6
  } error_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  slave_addr;
    logic [4:0]  length;
    logic        keep_bus;
    logic [3:0]  byte_index;
    logic [7:0]  tx_byte;
    logic [3:0]  status_code;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bus_action;
    logic [7:0]  data_out;
    logic        data_out_valid;
    logic        rx_store_valid;
    logic [3:0]  rx_store_index;
    logic [7:0]  rx_store_byte;
    logic        ready_res;
    logic [2:0]  error_code;
    logic        accepted;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

>>> hdl/i2c_master_transaction_sequencer.sv
// An item goes through in_q_r, then out_q_r, before out_valid; a stall may hold it.
// Throughput: one item per cycle; in_stall rises only when the result register is
// full and out_stall holds it.
// Reset (rst_n low, synchronous): bus phase ready, error success, all counters zero,
// pipeline empty. The payload store is not cleared.
module i2c_master_transaction_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cms_pkg::out_item_t  out_data
);

  i2cms_pkg::in_item_t   in_q_r;
  logic                  in_q_valid_r;
  i2cms_pkg::out_item_t  res;
  i2cms_pkg::out_item_t  out_q_r;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  fire;
  logic                  take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_q_valid_r && out_free;
  assign in_stall = in_q_valid_r && !out_free;
  assign take     = in_valid && !in_stall;

  i2cms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_q_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        in_q_valid_r <= 1'b1;
      end else if (fire) begin
        in_q_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q_r <= in_data;
    end
    if (fire) begin
      out_q_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

endmodule

>>> hdl/i2cms_tx_store.sv
module i2cms_tx_store (
  input  logic                       clk,
  input  i2cms_pkg::store_wr_t       wr,
  input  logic [i2cms_pkg::CNT_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem_r [i2cms_pkg::STORE_N];

  always_ff @(posedge clk) begin
    if (wr.we && (wr.addr <= i2cms_pkg::CNT_W'(i2cms_pkg::TX_MAX))) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = (rd_addr <= i2cms_pkg::CNT_W'(i2cms_pkg::TX_MAX)) ? mem_r[rd_addr] : 8'h00;

endmodule

>>> hdl/i2cms_core.sv
module i2cms_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  i2cms_pkg::in_item_t   item,
  output i2cms_pkg::out_item_t  res
);

  typedef enum logic [2:0] {
    PH_READY    = 3'd0,
    PH_REPSTART = 3'd1,
    PH_INIT     = 3'd2,
    PH_TX       = 3'd3,
    PH_RX       = 3'd4
  } phase_t;

  localparam int W = i2cms_pkg::CNT_W;
  localparam logic [W-1:0] TX_MAX_C = W'(i2cms_pkg::TX_MAX);
  localparam logic [W-1:0] RX_MAX_C = W'(i2cms_pkg::RX_MAX);

  phase_t                phase_r, phase_nxt;
  i2cms_pkg::error_t     err_r, err_nxt;
  logic                  hold_r, hold_nxt;
  logic [W-1:0]          send_pos_r, send_pos_nxt;
  logic [W-1:0]          send_cnt_r, send_cnt_nxt;
  logic [W-1:0]          recv_pos_r, recv_pos_nxt;
  logic [W-1:0]          recv_cnt_r, recv_cnt_nxt;

  i2cms_pkg::store_wr_t  wr;
  logic [7:0]            rd_data;
  logic [7:0]            sla;
  logic                  rd_cmd;
  logic                  ok;

  i2cms_tx_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (send_pos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    hold_nxt     = hold_r;
    send_pos_nxt = send_pos_r;
    send_cnt_nxt = send_cnt_r;
    recv_pos_nxt = recv_pos_r;
    recv_cnt_nxt = recv_cnt_r;
    wr           = '0;
    res          = '0;
    res.accepted = 1'b1;
    rd_cmd       = (item.mode == i2cms_pkg::MODE_READ);
    sla          = {item.slave_addr, rd_cmd};
    ok           = 1'b0;

    if (fire) begin
      case (i2cms_pkg::mode_t'(item.mode))
        i2cms_pkg::MODE_LOAD: begin
          if ({1'b0, item.byte_index} < TX_MAX_C) begin
            wr.we   = 1'b1;
            wr.addr = W'(item.byte_index) + W'(1);
            wr.data = item.tx_byte;
          end
        end
        i2cms_pkg::MODE_WRITE, i2cms_pkg::MODE_READ: begin
          ok = (phase_r == PH_READY) || (phase_r == PH_REPSTART);
          if (rd_cmd) begin
            if (item.length == '0 || item.length > RX_MAX_C) ok = 1'b0;
          end else begin
            if (item.length > TX_MAX_C) ok = 1'b0;
          end
          if (!ok) begin
            res.accepted = 1'b0;
          end else begin
            wr.we   = 1'b1;
            wr.addr = '0;
            wr.data = sla;
            if (rd_cmd) begin
              send_cnt_nxt = W'(1);
              recv_cnt_nxt = item.length;
              recv_pos_nxt = '0;
            end else begin
              send_cnt_nxt = item.length + W'(1);
            end
            send_pos_nxt = '0;
            hold_nxt     = item.keep_bus;
            if (phase_r == PH_REPSTART) begin
              res.data_out       = sla;
              res.data_out_valid = 1'b1;
              send_pos_nxt       = W'(1);
              res.bus_action     = i2cms_pkg::ACT_XFER;
            end else begin
              res.bus_action = i2cms_pkg::ACT_START;
            end
            phase_nxt = PH_INIT;
          end
        end
        default: begin
          case (item.status_code) inside
            i2cms_pkg::ST_START, i2cms_pkg::ST_MT_SLA_ACK, i2cms_pkg::ST_MT_DATA_ACK: begin
              if (item.status_code == i2cms_pkg::ST_MT_SLA_ACK) phase_nxt = PH_TX;
              if (send_pos_r < send_cnt_r && send_pos_r <= TX_MAX_C) begin
                res.data_out       = rd_data;
                res.data_out_valid = 1'b1;
                send_pos_nxt       = send_pos_r + W'(1);
                err_nxt            = i2cms_pkg::ERR_BUSY;
                res.bus_action     = i2cms_pkg::ACT_XFER;
              end else begin
                err_nxt = i2cms_pkg::ERR_SUCCESS;
                if (hold_r) begin
                  res.bus_action = i2cms_pkg::ACT_START;
                end else begin
                  phase_nxt      = PH_READY;
                  res.bus_action = i2cms_pkg::ACT_STOP;
                end
              end
            end
            i2cms_pkg::ST_MR_SLA_ACK, i2cms_pkg::ST_MR_DATA_ACK: begin
              if (item.status_code == i2cms_pkg::ST_MR_DATA_ACK && recv_pos_r < recv_cnt_r) begin
                res.rx_store_valid = 1'b1;
                res.rx_store_index = recv_pos_r[i2cms_pkg::IDX_W-1:0];
                res.rx_store_byte  = item.rx_byte;
                recv_pos_nxt       = recv_pos_r + W'(1);
              end
              phase_nxt = PH_RX;
              err_nxt   = i2cms_pkg::ERR_BUSY;
              if ({1'b0, recv_pos_nxt} + (W+1)'(1) < {1'b0, recv_cnt_r}) begin
                res.bus_action = i2cms_pkg::ACT_ACK;
              end else begin
                res.bus_action = i2cms_pkg::ACT_NAK;
              end
            end
            i2cms_pkg::ST_MR_DATA_NACK: begin
              if (recv_pos_r < recv_cnt_r) begin
                res.rx_store_valid = 1'b1;
                res.rx_store_index = recv_pos_r[i2cms_pkg::IDX_W-1:0];
                res.rx_store_byte  = item.rx_byte;
                recv_pos_nxt       = recv_pos_r + W'(1);
              end
              err_nxt = i2cms_pkg::ERR_SUCCESS;
              if (hold_r) begin
                res.bus_action = i2cms_pkg::ACT_START;
              end else begin
                phase_nxt      = PH_READY;
                res.bus_action = i2cms_pkg::ACT_STOP;
              end
            end
            i2cms_pkg::ST_MT_SLA_NACK, i2cms_pkg::ST_MT_DATA_NACK, i2cms_pkg::ST_ARB_LOST,
            i2cms_pkg::ST_MR_SLA_NACK: begin
              case (item.status_code)
                i2cms_pkg::ST_MT_SLA_NACK:  err_nxt = i2cms_pkg::ERR_WADDR_NAK;
                i2cms_pkg::ST_MT_DATA_NACK: err_nxt = i2cms_pkg::ERR_DATA_NAK;
                i2cms_pkg::ST_ARB_LOST:     err_nxt = i2cms_pkg::ERR_ARB_LOST;
                default:                    err_nxt = i2cms_pkg::ERR_RADDR_NAK;
              endcase
              if (hold_r) begin
                res.bus_action = i2cms_pkg::ACT_START;
              end else begin
                phase_nxt      = PH_READY;
                res.bus_action = i2cms_pkg::ACT_STOP;
              end
            end
            i2cms_pkg::ST_REP_START: begin
              phase_nxt = PH_REPSTART;
            end
            i2cms_pkg::ST_BUS_ERROR: begin
              err_nxt        = i2cms_pkg::ERR_BUS;
              phase_nxt      = PH_READY;
              res.bus_action = i2cms_pkg::ACT_STOP;
            end
            default: begin
            end
          endcase
        end
      endcase
    end

    res.ready_res  = (phase_nxt == PH_READY) || (phase_nxt == PH_REPSTART);
    res.error_code = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_READY;
      err_r      <= i2cms_pkg::ERR_SUCCESS;
      hold_r     <= 1'b0;
      send_pos_r <= '0;
      send_cnt_r <= '0;
      recv_pos_r <= '0;
      recv_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
      hold_r     <= hold_nxt;
      send_pos_r <= send_pos_nxt;
      send_cnt_r <= send_cnt_nxt;
      recv_pos_r <= recv_pos_nxt;
      recv_cnt_r <= recv_cnt_nxt;
    end
  end

endmodule

>>> hdl/i2cms_checker.sv
module i2cms_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  i2cms_pkg::out_item_t  out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.bus_action == i2cms_pkg::ACT_NONE && !out_data.data_out_valid)
    else $error("rejected command drove the bus");

  a_xfer_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.data_out_valid == (out_data.bus_action == i2cms_pkg::ACT_XFER))
    else $error("data byte and transfer action disagree");

  a_rx_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_store_valid |->
      out_data.error_code == i2cms_pkg::ERR_SUCCESS ||
      out_data.error_code == i2cms_pkg::ERR_BUSY)
    else $error("received byte with error status");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);
